>>> design/dsc_pkg.sv
// Package for the distinct subsequence counter: field widths, payload types,
// the prime modulus and default parameter values. No dependencies.
`timescale 1ns / 1ps

package dsc_pkg;

   localparam int SYM_W        = 8;
   localparam int COUNT_W      = 30;
   localparam int DEF_SYMBOLS  = 256;

   typedef logic [SYM_W-1:0]   sym_type;
   typedef logic [COUNT_W-1:0] count_type;

   // Counts are kept modulo this prime.
   localparam count_type MODULUS    = count_type'(1000000007);
   localparam count_type COUNT_INIT = count_type'(1);

endpackage

>>> design/dsc_if.sv
// Handshake interfaces for the symbol channel and the count channel.
// Depends on dsc_pkg for the payload types.
`timescale 1ns / 1ps

interface dsc_req_if import dsc_pkg::*; ();
   logic    valid;
   logic    ready;
   sym_type symbol;
   logic    last_symbol;

   modport source (output valid, output symbol, output last_symbol, input ready);
   modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

interface dsc_rsp_if import dsc_pkg::*; ();
   logic      valid;
   logic      ready;
   count_type count;
   logic      final_res;

   modport source (output valid, output count, output final_res, input ready);
   modport sink   (input valid, input count, input final_res, output ready);
endinterface

>>> design/distinct_subsequence_counter.sv
// Top level of the distinct subsequence counter.
// Depends on dsc_pkg, the interfaces in dsc_if and the RAM in dsc_ram.
`timescale 1ns / 1ps

// Usage:
// The req channel carries one symbol per word, with last_symbol set on the
// final symbol of a string. For every accepted word the rsp channel returns
// one word: count is the number of distinct subsequences of the string so far
// (empty one included) modulo 1000000007, and final_res repeats last_symbol.
// The accepted word and its table read are registered in the update stage, and
// the result in the output register. Throughput is one word per cycle while the
// receiver does not stall: the table read for a symbol is issued on acceptance,
// and the modular update and table write-back happen in the update stage, with
// the last write forwarded to a read of the same entry that overlaps it.
// Symbols at or above SYMBOLS use entry (symbol mod SYMBOLS).
// Reset sets the count to one and clears the seen marks; the table needs no
// clearing pass, since an entry is only used after it has been written.
// After a word with last_symbol the count returns to one and all marks clear.
// When the receiver stalls, the result waits in the output register, one
// more word waits in the update stage, and then req.ready drops.
module distinct_subsequence_counter import dsc_pkg::*; #(
   parameter int SYMBOLS = DEF_SYMBOLS
) (
   input  logic  clock,
   input  logic  reset,
   dsc_req_if.sink   req,
   dsc_rsp_if.source rsp
);

   localparam int IDX_W = $clog2(SYMBOLS);
   localparam int CODES = 2 ** SYM_W;

   typedef logic [IDX_W-1:0] idx_type;

   // Constant table folding a byte code onto a table entry.
   idx_type sym_map [CODES];
   for (genvar g = 0; g < CODES; g++) begin : g_map
      assign sym_map[g] = idx_type'(g % SYMBOLS);
   end

   idx_type      req_idx;
   logic         req_fire;
   logic         s1_valid_ff, s1_valid_in;
   idx_type      s1_idx_ff;
   logic         s1_last_ff;
   logic         s1_fire;
   count_type    count_ff, count_in;
   logic [SYMBOLS-1:0] seen_ff, seen_in;
   logic         fwd_valid_ff;
   idx_type      fwd_addr_ff;
   count_type    fwd_data_ff;
   count_type    ram_rd_data;
   count_type    prior;
   logic [31:0]  diff;
   logic [31:0]  diff_fix;
   count_type    next_count;
   logic         rsp_valid_ff, rsp_valid_in;
   count_type    rsp_count_ff;
   logic         rsp_final_ff;

   assign req_idx  = sym_map[req.symbol];
   assign s1_fire  = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || s1_fire;
   assign req_fire = req.valid && req.ready;

   dsc_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (SYMBOLS)
   ) u_table (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_idx_ff),
      .wr_data (count_ff),
      .rd_en   (req_fire),
      .rd_addr (req_idx),
      .rd_data (ram_rd_data)
   );

   // The read for a word can be issued in the cycle its predecessor writes
   // the same entry, so the most recent write is held and forwarded.
   assign prior = (fwd_valid_ff && fwd_addr_ff == s1_idx_ff) ? fwd_data_ff : ram_rd_data;

   // 2*C - P lies strictly between -M and 2*M, so one correction suffices.
   always_comb begin
      diff = {1'b0, count_ff, 1'b0};
      if (seen_ff[s1_idx_ff]) begin
         diff = diff - {2'b00, prior};
      end
      if (diff[31]) begin
         diff_fix = diff + {2'b00, MODULUS};
      end else if (diff >= {2'b00, MODULUS}) begin
         diff_fix = diff - {2'b00, MODULUS};
      end else begin
         diff_fix = diff;
      end
      next_count = diff_fix[COUNT_W-1:0];
   end

   always_comb begin
      s1_valid_in  = s1_fire ? 1'b0 : s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end
      count_in     = count_ff;
      seen_in      = seen_ff;
      if (s1_fire) begin
         if (s1_last_ff) begin
            count_in = COUNT_INIT;
            seen_in  = '0;
         end else begin
            count_in = next_count;
            seen_in[s1_idx_ff] = 1'b1;
         end
      end
      rsp_valid_in = (rsp_valid_ff && !rsp.ready) || s1_fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         count_ff     <= COUNT_INIT;
         seen_ff      <= '0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         count_ff     <= count_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            fwd_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_idx_ff  <= req_idx;
         s1_last_ff <= req.last_symbol;
      end
      if (s1_fire) begin
         fwd_addr_ff  <= s1_idx_ff;
         fwd_data_ff  <= count_ff;
         rsp_count_ff <= next_count;
         rsp_final_ff <= s1_last_ff;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.count     = rsp_count_ff;
   assign rsp.final_res = rsp_final_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.count < MODULUS)
      else $error("count word out of range");

   a_end_restart: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_last_ff) |=> (count_ff == COUNT_INIT && seen_ff == '0))
      else $error("string state not restarted after last symbol");

   a_stall_backpressure: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp.ready) |-> !req.ready)
      else $error("word accepted while update stage is blocked");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> (rsp.valid && rsp.count == $past(next_count)))
      else $error("result word lost after update");

endmodule

>>> design/dsc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module dsc_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
